### src/lfbe_pkg.sv
package lfbe_pkg;

  // Opcodes of the command field
  localparam logic [2:0] OP_UVAR   = 3'd0;
  localparam logic [2:0] OP_SVAR   = 3'd1;
  localparam logic [2:0] OP_UDELTA = 3'd2;
  localparam logic [2:0] OP_SDELTA = 3'd3;
  localparam logic [2:0] OP_RAW    = 3'd4;
  localparam logic [2:0] OP_FLUSH  = 3'd5;

  // Widths
  localparam int WORD_W = 32;
  localparam int BUF_W  = 2 * WORD_W;   // bit buffer: pending bits plus the longest code
  localparam int CNT_W  = 6;            // holds buffer fill up to 63 bits
  localparam int LEN_W  = 6;            // bit length of a word, 0..32
  localparam int BYTE_W = 8;

  localparam logic [WORD_W-1:0] ESC_LIMIT = 32'hFFFFFFFF;

  // Source of the bits appended to the buffer in one cycle
  typedef enum logic [2:0] {
    APP_NONE  = 3'd0,
    APP_RAW   = 3'd1,
    APP_LEN   = 3'd2,
    APP_VBITS = 3'd3,
    APP_ESC   = 3'd4
  } app_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic     load;      // latch the accepted beat
    logic     len_lat;   // latch the bit length from the leading-one unit
    app_sel_t app_sel;   // append a field to the bit buffer
    logic     emit_buf;  // send the top byte of the bit buffer
    logic     emit_var;  // send the next varint group
    logic     flush;     // partial byte counts as available
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;   // output register can take a byte this cycle
    logic buf_avail;  // bit buffer holds a byte to send
    logic buf_last;   // that byte is the last of the item
    logic var_last;   // current varint group is the last
    logic esc;        // delta code needs the trailing escape bit
  } dp_stat_t;

endpackage

### src/lfbe_lzc.sv
// Two-stage bit-length unit: per-byte lengths are registered, then combined.
module lfbe_lzc (
  input  logic                       clk,
  input  logic [lfbe_pkg::WORD_W-1:0] data,
  output logic [lfbe_pkg::LEN_W-1:0]  bit_len
);

  localparam int GROUPS = lfbe_pkg::WORD_W / lfbe_pkg::BYTE_W;

  logic [3:0]        grp_len_nxt [GROUPS];
  logic [3:0]        grp_len_r   [GROUPS];
  logic [GROUPS-1:0] grp_nz_nxt;
  logic [GROUPS-1:0] grp_nz_r;

  // Stage 1: bit length of each byte
  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      grp_len_nxt[g] = 4'd0;
      for (int b = 0; b < lfbe_pkg::BYTE_W; b++) begin
        if (data[g*lfbe_pkg::BYTE_W + b]) begin
          grp_len_nxt[g] = 4'(b + 1);
        end
      end
      grp_nz_nxt[g] = |data[g*lfbe_pkg::BYTE_W +: lfbe_pkg::BYTE_W];
    end
  end

  always_ff @(posedge clk) begin
    grp_len_r <= grp_len_nxt;
    grp_nz_r  <= grp_nz_nxt;
  end

  // Stage 2: highest non-zero byte decides
  always_comb begin
    bit_len = '0;
    priority if (grp_nz_r[3]) begin
      bit_len = lfbe_pkg::LEN_W'(3 * lfbe_pkg::BYTE_W) + {2'b00, grp_len_r[3]};
    end else if (grp_nz_r[2]) begin
      bit_len = lfbe_pkg::LEN_W'(2 * lfbe_pkg::BYTE_W) + {2'b00, grp_len_r[2]};
    end else if (grp_nz_r[1]) begin
      bit_len = lfbe_pkg::LEN_W'(lfbe_pkg::BYTE_W) + {2'b00, grp_len_r[1]};
    end else begin
      bit_len = {2'b00, grp_len_r[0]};
    end
  end

endmodule

### src/lfbe_dp.sv
// Datapath: operand prep, bit buffer, varint shifter and output register.
module lfbe_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lfbe_pkg::ctrl_cmd_t         cmd,
  output lfbe_pkg::dp_stat_t          stat,
  input  logic [2:0]                  in_opcode,
  input  logic [lfbe_pkg::WORD_W-1:0] in_value,
  input  logic [5:0]                  in_bit_count,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  out_byte_value,
  output logic                        out_last_byte
);

  localparam int WW = lfbe_pkg::WORD_W;
  localparam int BW = lfbe_pkg::BUF_W;
  localparam int CW = lfbe_pkg::CNT_W;
  localparam int LW = lfbe_pkg::LEN_W;

  function automatic logic [2:0] len_of_len(input logic [LW-1:0] x);
    logic [2:0] n;
    n = 3'd0;
    for (int b = 0; b < LW; b++) begin
      if (x[b]) begin
        n = 3'(b + 1);
      end
    end
    return n;
  endfunction

  logic [WW-1:0] var_r, var_nxt;     // varint shifter, also raw operand
  logic [WW-1:0] dv_r;               // delta operand (value+1 or escape)
  logic          esc_r, escbit_r;
  logic [LW-1:0] rawn_r;
  logic [LW-1:0] len_r;
  logic [BW-1:0] buf_r, buf_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          out_valid_r;
  logic [7:0]    out_byte_r;
  logic          out_last_r;

  logic [WW-1:0]   zz, word;
  logic            word_esc;
  logic [LW-1:0]   lz_len;
  logic [2:0]      lenlen;
  logic [3:0]      fld_w;
  logic [WW-1:0]   app_src;
  logic [LW-1:0]   app_len;
  logic [2*WW-1:0] al_wide;
  logic [BW-1:0]   ins;
  logic            out_free;

  // Operand prep for the accepted beat
  always_comb begin
    zz       = {in_value[WW-2:0], 1'b0} ^ {WW{in_value[WW-1]}};
    word     = (in_opcode == lfbe_pkg::OP_SVAR || in_opcode == lfbe_pkg::OP_SDELTA) ?
               zz : in_value;
    word_esc = &word[WW-1:1];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      esc_r    <= word_esc;
      escbit_r <= word[0];
      dv_r     <= word_esc ? lfbe_pkg::ESC_LIMIT : word + WW'(1);
      rawn_r   <= (in_bit_count > LW'(WW)) ? LW'(WW) : in_bit_count;
    end
    if (cmd.len_lat) begin
      len_r <= lz_len;
    end
  end

  lfbe_lzc u_lzc (
    .clk     (clk),
    .data    (dv_r),
    .bit_len (lz_len)
  );

  // Field to append, left aligned
  always_comb begin
    lenlen  = len_of_len(len_r);
    fld_w   = {lenlen, 1'b0} - 4'd1;
    app_src = '0;
    app_len = '0;
    unique case (cmd.app_sel)
      lfbe_pkg::APP_NONE: begin
        app_src = '0;
        app_len = '0;
      end
      lfbe_pkg::APP_RAW: begin
        app_src = var_r;
        app_len = rawn_r;
      end
      lfbe_pkg::APP_LEN: begin
        app_src = {{(WW-LW){1'b0}}, len_r};
        app_len = {2'b00, fld_w};
      end
      lfbe_pkg::APP_VBITS: begin
        app_src = dv_r;
        app_len = len_r - LW'(1);
      end
      lfbe_pkg::APP_ESC: begin
        app_src = {{(WW-1){1'b0}}, escbit_r};
        app_len = LW'(1);
      end
      default: begin
        app_src = '0;
        app_len = '0;
      end
    endcase
    al_wide = {app_src, {WW{1'b0}}} >> app_len;
    ins     = {al_wide[WW-1:0], {(BW-WW){1'b0}}} >> cnt_r;
  end

  // Bit buffer and varint shifter
  always_comb begin
    buf_nxt = buf_r;
    cnt_nxt = cnt_r;
    var_nxt = var_r;
    if (cmd.load) begin
      var_nxt = word;
    end else if (cmd.emit_var) begin
      var_nxt = var_r >> 7;
    end
    if (cmd.emit_buf) begin
      buf_nxt = buf_r << 8;
      cnt_nxt = cmd.flush ? '0 : cnt_r - CW'(8);
    end else begin
      buf_nxt = buf_r | ins;
      cnt_nxt = cnt_r + CW'(app_len);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_r <= '0;
      cnt_r <= '0;
    end else begin
      buf_r <= buf_nxt;
      cnt_r <= cnt_nxt;
    end
    var_r <= var_nxt;
  end

  // Output register
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_buf || cmd.emit_var) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.emit_buf) begin
      out_byte_r <= buf_r[BW-1 -: 8];
      out_last_r <= stat.buf_last;
    end else if (cmd.emit_var) begin
      out_byte_r <= {stat.var_last ? 1'b0 : 1'b1, var_r[6:0]};
      out_last_r <= stat.var_last;
    end
  end

  // Status
  always_comb begin
    stat.out_free  = out_free;
    stat.buf_avail = (cnt_r >= CW'(8)) || (cmd.flush && cnt_r != '0);
    stat.buf_last  = cmd.flush || (cnt_r < CW'(16));
    stat.var_last  = (var_r[WW-1:7] == '0);
    stat.esc       = esc_r;
  end

  assign out_valid      = out_valid_r;
  assign out_byte_value = out_byte_r;
  assign out_last_byte  = out_last_r;

endmodule

### src/lfbe_ctrl.sv
// Controller: sequences one command through append and byte-send steps.
module lfbe_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          in_opcode,
  input  lfbe_pkg::dp_stat_t  stat,
  output lfbe_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_LZ1   = 10'b00_0000_0010,
    S_LZ2   = 10'b00_0000_0100,
    S_LEN   = 10'b00_0000_1000,
    S_VBITS = 10'b00_0001_0000,
    S_ESC   = 10'b00_0010_0000,
    S_RAW   = 10'b00_0100_0000,
    S_EMIT  = 10'b00_1000_0000,
    S_FLUSH = 10'b01_0000_0000,
    S_VAR   = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt    = state_r;
    cmd.load     = 1'b0;
    cmd.len_lat  = 1'b0;
    cmd.app_sel  = lfbe_pkg::APP_NONE;
    cmd.emit_buf = 1'b0;
    cmd.emit_var = 1'b0;
    cmd.flush    = (state_r == S_FLUSH);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          priority if (in_opcode == lfbe_pkg::OP_UVAR || in_opcode == lfbe_pkg::OP_SVAR) begin
            state_nxt = S_VAR;
          end else if (in_opcode == lfbe_pkg::OP_UDELTA ||
                       in_opcode == lfbe_pkg::OP_SDELTA) begin
            state_nxt = S_LZ1;
          end else if (in_opcode == lfbe_pkg::OP_RAW) begin
            state_nxt = S_RAW;
          end else if (in_opcode == lfbe_pkg::OP_FLUSH) begin
            state_nxt = S_FLUSH;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_LZ1: begin
        state_nxt = S_LZ2;
      end
      S_LZ2: begin
        cmd.len_lat = 1'b1;
        state_nxt   = S_LEN;
      end
      S_LEN: begin
        cmd.app_sel = lfbe_pkg::APP_LEN;
        state_nxt   = S_VBITS;
      end
      S_VBITS: begin
        cmd.app_sel = lfbe_pkg::APP_VBITS;
        state_nxt   = stat.esc ? S_ESC : S_EMIT;
      end
      S_ESC: begin
        cmd.app_sel = lfbe_pkg::APP_ESC;
        state_nxt   = S_EMIT;
      end
      S_RAW: begin
        cmd.app_sel = lfbe_pkg::APP_RAW;
        state_nxt   = S_EMIT;
      end
      S_EMIT, S_FLUSH: begin
        if (!stat.buf_avail) begin
          state_nxt = S_IDLE;
        end else if (stat.out_free) begin
          cmd.emit_buf = 1'b1;
          if (stat.buf_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_VAR: begin
        if (stat.out_free) begin
          cmd.emit_var = 1'b1;
          if (stat.var_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### src/log_field_byte_encoder_top.sv
// Field encoder: one command beat in, a run of byte beats out.
// Input channel (in_valid/in_stall): opcode, 32-bit value and bit count. Opcodes: unsigned
// and zigzag varint, unsigned and zigzag Elias delta, raw MSB-first bits, flush.
// Output channel (out_valid/out_stall): one byte per beat, out_last_byte marks the final
// byte of a command. Commands that produce nothing (raw with zero count, flush with no
// pending bits, unused opcodes) give no output beat.
// One command is worked at a time; in_stall is high until its last byte has entered the
// output register. Varint: after the accept, one byte per cycle while out_stall is low.
// Elias delta: bit assembly (two-stage leading-one unit, then one field appended per cycle)
// followed by one byte per cycle while out_stall is low, up to 6 bytes. Raw bits: the bits
// are appended, then sent as bytes in the same way.
// The single output register sets the byte rate; when out_stall is high the held byte
// stays put and the controller waits, so no byte is lost or repeated.
// Reset (rst_n low, synchronous) clears the pending partial byte, the controller and the
// output valid; the block can take a command in the first cycle after reset.
module log_field_byte_encoder_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_opcode,
  input  logic [31:0] in_value,
  input  logic [5:0]  in_bit_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte_value,
  output logic        out_last_byte
);

  lfbe_pkg::ctrl_cmd_t cmd;
  lfbe_pkg::dp_stat_t  stat;

  lfbe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_opcode (in_opcode),
    .stat      (stat),
    .cmd       (cmd)
  );

  lfbe_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_opcode      (in_opcode),
    .in_value       (in_value),
    .in_bit_count   (in_bit_count),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte_value (out_byte_value),
    .out_last_byte  (out_last_byte)
  );

endmodule
